### hw/rtl/bst_pkg.sv
// ============================================================================
// bst_pkg: shared types and constants for the binary search table
// Field widths of the request and response words, function codes and
// special result codes.
// ============================================================================
package bst_pkg;

  localparam int SIZE_W  = 5;   // table_size register
  localparam int INDEX_W = 4;   // entry_index field
  localparam int VALUE_W = 32;  // entry data / search target
  localparam int POS_W   = 5;   // position field
  localparam int PROBE_W = 3;   // probe_count field

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_t;

  // position reported when the target is absent (-1)
  localparam logic [POS_W-1:0]   POS_NONE  = '1;
  // probe counter saturates here
  localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

endpackage

### hw/rtl/bst_req_if.sv
// ============================================================================
// bst_req_if: request channel
// One word is a load (entry_index, value) or a search (value is the target).
// ============================================================================
interface bst_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [bst_pkg::INDEX_W-1:0]   entry_index;
  logic signed [bst_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output entry_index, output value,
                  input ready);
  modport sink   (input valid, input func, input entry_index, input value,
                  output ready);
endinterface

### hw/rtl/bst_rsp_if.sv
// ============================================================================
// bst_rsp_if: response channel
// One word per search: found flag, position (-1 if absent), probe count.
// ============================================================================
interface bst_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic signed [bst_pkg::POS_W-1:0]   position;
  logic [bst_pkg::PROBE_W-1:0]        probe_count;

  modport source (output valid, output found, output position, output probe_count,
                  input ready);
  modport sink   (input valid, input found, input position, input probe_count,
                  output ready);
endinterface

### hw/rtl/binary_search_table_core.sv
// ============================================================================
// binary_search_table_core: pipelined binary search over a loaded table
// Loads signed 32-bit entries and answers search requests by binary search.
// ============================================================================
//
// Usage
//   req  : valid/ready channel. func = load writes value at entry_index
//          (ignored when entry_index >= TABLE_DEPTH); func = search looks
//          for value among entries 0 .. min(table_size, TABLE_DEPTH)-1.
//   rsp  : one word per search: found, position (-1 if absent) and the
//          number of probes, the hitting probe included. Loads give none.
//   cfg  : cfg_we / cfg_data write table_size; write it only while idle.
//   Each probe is one pipeline stage with its own copy of the table
//   (NPROBE = clog2(TABLE_DEPTH+1) stages, 5 for a depth of 16). Loads walk
//   the same stages and update each copy in order, so a search sees exactly
//   the loads accepted before it.
//   An accepted word passes stage 0, the probe stages and then the response
//   register. Throughput: one word per cycle, loads or searches, unless rsp stalls.
//   Reset (rst, synchronous) empties the pipeline and clears table_size;
//   table contents are undefined until loaded.
//   A stall on rsp freezes the whole pipeline and drops req.ready; nothing
//   is lost or repeated.
//
module binary_search_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bst_pkg::SIZE_W-1:0]  cfg_data,
  bst_req_if.sink                     req,
  bst_rsp_if.source                   rsp
);
  // ---- derived sizes ----
  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1; // table address
  localparam int CW     = $clog2(TABLE_DEPTH + 1);                     // bound 0..DEPTH
  localparam int NPROBE = $clog2(TABLE_DEPTH + 1);                     // max probes

  // one pipeline word: loads and searches share the stages
  typedef struct packed {
    logic                              valid;
    logic                              search;
    logic                              wr_en;   // in-range load
    logic [AW-1:0]                     waddr;
    logic signed [bst_pkg::VALUE_W-1:0] value;  // entry data or target
    logic [CW-1:0]                     lo;      // inclusive lower bound
    logic [CW-1:0]                     hi_p1;   // exclusive upper bound
    logic                              active;  // search still probing
    logic                              hit;
    logic [AW-1:0]                     mid;     // address read last stage
    logic [AW-1:0]                     pos;
    logic [bst_pkg::PROBE_W-1:0]       probes;
  } stage_t;

  // ---- config register ----
  logic [bst_pkg::SIZE_W-1:0] table_size;
  logic [CW-1:0]              num_entries;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= '0;
    end else if (cfg_we) begin
      table_size <= cfg_data;
    end
  end

  // table_size saturates at the depth
  always_comb begin
    if (32'(table_size) > 32'(TABLE_DEPTH)) begin
      num_entries = CW'(TABLE_DEPTH);
    end else begin
      num_entries = CW'(table_size);
    end
  end

  // ---- pipeline control ----
  // Whole pipeline moves together; it only holds when a response waits.
  logic adv;
  assign adv       = !(rsp.valid && !rsp.ready);
  assign req.ready = adv;

  stage_t                             st    [NPROBE+1]; // stage registers
  stage_t                             rs    [NPROBE+1]; // after probe resolve
  logic [AW-1:0]                      mid   [NPROBE];   // next probe address
  logic signed [bst_pkg::VALUE_W-1:0] rdata [NPROBE];

  // ---- stage 0: accept a word ----
  stage_t st0_next;

  always_comb begin
    st0_next        = '0;
    st0_next.valid  = req.valid;
    st0_next.search = (req.func == bst_pkg::FUNC_SEARCH);
    st0_next.wr_en  = (req.func == bst_pkg::FUNC_LOAD) &&
                      (32'(req.entry_index) < 32'(TABLE_DEPTH));
    st0_next.waddr  = AW'(req.entry_index);
    st0_next.value  = req.value;
    st0_next.lo     = '0;
    st0_next.hi_p1  = num_entries;
    st0_next.active = (req.func == bst_pkg::FUNC_SEARCH) && (num_entries != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (adv) begin
      st[0] <= st0_next;
    end
  end

  assign rs[0] = st[0];

  genvar k;
  generate
    // ---- probe resolve: compare the entry read last stage ----
    for (k = 1; k <= NPROBE; k++) begin : g_resolve
      always_comb begin
        rs[k] = st[k];
        if (st[k].active) begin
          if (st[k].probes != bst_pkg::PROBE_MAX) begin
            rs[k].probes = st[k].probes + 1'b1;
          end
          if (rdata[k-1] == st[k].value) begin
            rs[k].hit    = 1'b1;
            rs[k].pos    = st[k].mid;
            rs[k].active = 1'b0;
          end else begin
            if (rdata[k-1] < st[k].value) begin
              rs[k].lo = CW'(st[k].mid) + 1'b1;
            end else begin
              rs[k].hi_p1 = CW'(st[k].mid);
            end
            rs[k].active = (rs[k].lo < rs[k].hi_p1);
          end
        end
      end
    end

    // ---- probe issue: one table copy per stage ----
    for (k = 0; k < NPROBE; k++) begin : g_probe
      logic [CW:0] bound_sum;
      stage_t      st_next;

      // floor((lo + hi) / 2) with hi = hi_p1 - 1
      assign bound_sum = {1'b0, rs[k].lo} + {1'b0, rs[k].hi_p1} - 1'b1;
      assign mid[k]    = AW'(bound_sum >> 1);

      // carry the probe address along with the word
      always_comb begin
        st_next     = rs[k];
        st_next.mid = mid[k];
      end

      // loads write this copy as they pass, searches read it
      bst_ram #(
        .WIDTH (bst_pkg::VALUE_W),
        .DEPTH (TABLE_DEPTH)
      ) u_ram (
        .clk   (clk),
        .we    (adv && st[k].valid && st[k].wr_en),
        .waddr (st[k].waddr),
        .wdata (st[k].value),
        .re    (adv),
        .raddr (mid[k]),
        .rdata (rdata[k])
      );

      always_ff @(posedge clk) begin
        if (rst) begin
          st[k+1].valid <= 1'b0;
        end else if (adv) begin
          st[k+1] <= st_next;
        end
      end
    end
  endgenerate

  // ---- response register ----
  logic                        rsp_valid;
  logic                        rsp_found;
  logic [bst_pkg::POS_W-1:0]   rsp_position;
  logic [bst_pkg::PROBE_W-1:0] rsp_probes;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= st[NPROBE].valid && st[NPROBE].search;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_found    <= rs[NPROBE].hit;
      rsp_position <= rs[NPROBE].hit ? bst_pkg::POS_W'(rs[NPROBE].pos)
                                     : bst_pkg::POS_NONE;
      rsp_probes   <= rs[NPROBE].probes;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.found       = rsp_found;
  assign rsp.position    = rsp_position;
  assign rsp.probe_count = rsp_probes;

endmodule

### hw/rtl/bst_ram.sv
// ============================================================================
// bst_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
module bst_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### tb/binary_search_table_core_test.sv
`timescale 1ns / 100ps
// ============================================================================
// binary_search_table_core_test: self-checking bench for the search table
// Loads tables, sorted and otherwise, and sweeps table_size across its full
// 5-bit range. Every accepted search word is predicted by a local binary
// search over a shadow copy of the table. Response words are matched in
// order. Both channels idle in random bursts, and one long response stall
// backs up the pipeline.
// ============================================================================
module binary_search_table_core_test;

  localparam int TABLE_DEPTH  = 16;
  localparam int DRAIN_CYCLES = 16;      // extra wait after the last pending response
  localparam int LIMIT_CYCLES = 300000;
  localparam int PHASE_WORDS  = 44;      // words per random phase after the load

  typedef struct packed {
    logic                              found;
    logic signed [bst_pkg::POS_W-1:0]  position;
    logic [bst_pkg::PROBE_W-1:0]       probe_count;
  } lookup_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [bst_pkg::SIZE_W-1:0]  cfg_data;

  bst_req_if req ();
  bst_rsp_if rsp ();

  binary_search_table_core #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp)
  );

  // Shadow state: table contents and table_size as the block should see them.
  logic signed [bst_pkg::VALUE_W-1:0] table_copy [TABLE_DEPTH];
  logic [bst_pkg::SIZE_W-1:0]         size_copy;
  lookup_t                            lookups_due [$];   // predicted words, oldest first
  lookup_t                            got, want;

  int error_count = 0;
  int cycle_count = 0;
  int hold_cycles = 0;   // long response stall, counted down by the ready process
  int stall_left  = 0;
  int phase_no    = 0;
  bit send_gaps   = 1'b1;
  bit rsp_gaps    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // table_size above the depth saturates
  function automatic int search_span();
    return (size_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_copy);
  endfunction

  // Floor-midpoint binary search over the shadow table, signed compare.
  function automatic lookup_t lookup_table(logic signed [bst_pkg::VALUE_W-1:0] target);
    lookup_t r;
    int lo, hi, mid, probes;
    r.found       = 1'b0;
    r.position    = bst_pkg::POS_NONE;
    r.probe_count = '0;
    probes = 0;
    lo = 0;
    hi = search_span() - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      probes++;
      if (table_copy[mid] == target) begin
        r.found    = 1'b1;
        r.position = mid[bst_pkg::POS_W-1:0];
        break;
      end else if (table_copy[mid] < target) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    if (probes > int'(bst_pkg::PROBE_MAX)) r.probe_count = bst_pkg::PROBE_MAX;
    else r.probe_count = probes[bst_pkg::PROBE_W-1:0];
    return r;
  endfunction

  // Mostly hits, some near misses, some arbitrary values and extremes.
  function automatic logic signed [bst_pkg::VALUE_W-1:0] pick_target();
    int span;
    logic signed [bst_pkg::VALUE_W-1:0] hit_val;
    span = search_span();
    if (span == 0) return $urandom;
    hit_val = table_copy[$urandom_range(0, span - 1)];
    case ($urandom_range(0, 9))
      6: return hit_val + 1;
      7: return hit_val - 1;
      8: return $urandom;
      9: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return hit_val;
    endcase
  endfunction

  // One request word; valid stays up across back-to-back words.
  task automatic send_word(bst_pkg::func_t fn, logic [bst_pkg::INDEX_W-1:0] idx,
                           logic signed [bst_pkg::VALUE_W-1:0] val);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.func        <= fn;
    req.entry_index <= idx;
    req.value       <= val;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    // accepted at this edge; loads update the shadow, searches get predicted
    if (fn == bst_pkg::FUNC_LOAD) table_copy[idx] = val;
    else lookups_due.push_back(lookup_table(val));
  endtask

  // Drop valid, wait for every pending response, then let trailing loads drain.
  task automatic settle();
    req.valid <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [bst_pkg::SIZE_W-1:0] n);
    cfg_we   <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_copy  = n;
  endtask

  // Rewrites all 16 entries in shuffled index order.
  // style 2: dense values with duplicates, 3: both extremes present,
  // 4: unsorted, 5: descending, otherwise ascending spread.
  task automatic load_table(int style);
    int col [$];
    int slot [$];
    int base;
    base = $urandom;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot.push_back(i);
      if (style == 2) col.push_back(base + int'($urandom_range(0, 24)));
      else col.push_back($urandom);
    end
    if (style == 3) begin
      col[0] = 32'sh8000_0000;
      col[1] = 32'sh7fff_ffff;
    end
    if (style == 5) col.rsort();
    else if (style != 4) col.sort();
    slot.shuffle();
    foreach (slot[k])
      send_word(bst_pkg::FUNC_LOAD, slot[k][bst_pkg::INDEX_W-1:0], col[slot[k]]);
  endtask

  // Search on the reset size, before anything is loaded: no probes at all.
  task automatic test_empty_table();
    send_word(bst_pkg::FUNC_SEARCH, 4'hA, 32'sd12345);
  endtask

  // Ascending table from the most negative to the most positive value.
  task automatic test_sorted_extremes();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0) send_word(bst_pkg::FUNC_LOAD, 4'd0, 32'sh8000_0000);
      else if (i == TABLE_DEPTH - 1) send_word(bst_pkg::FUNC_LOAD, 4'hF, 32'sh7fff_ffff);
      else send_word(bst_pkg::FUNC_LOAD, i[bst_pkg::INDEX_W-1:0], (i - 7) * 1000);
    end
    settle();
    write_size(5'd16);
    send_word(bst_pkg::FUNC_SEARCH, 4'h0, 32'sh8000_0000);  // leftmost, deep miss path
    send_word(bst_pkg::FUNC_SEARCH, 4'hF, 32'sh7fff_ffff);  // rightmost, full depth
    send_word(bst_pkg::FUNC_SEARCH, 4'h5, 32'sd0);          // hit on the first probe
    send_word(bst_pkg::FUNC_SEARCH, 4'h3, 32'sd500);        // absent, between entries
  endtask

  // Oversized register saturates to the depth; a one-entry table.
  task automatic test_size_limits();
    settle();
    write_size(5'd31);
    send_word(bst_pkg::FUNC_SEARCH, 4'h9, 32'sh7fff_ffff);
    settle();
    write_size(5'd1);
    send_word(bst_pkg::FUNC_SEARCH, 4'h1, 32'sh8000_0000);
    send_word(bst_pkg::FUNC_SEARCH, 4'hE, 32'sd0);
  endtask

  task automatic test_random_tables(int phases, bit with_gaps);
    logic [bst_pkg::SIZE_W-1:0] n;
    send_gaps = with_gaps;
    rsp_gaps  = with_gaps;
    repeat (phases) begin
      // first phases walk the corner sizes, later ones mostly in range
      case (phase_no)
        0: n = 5'd0;
        1: n = 5'd1;
        2: n = 5'd2;
        3: n = 5'd16;
        4: n = 5'd17;
        5: n = 5'd31;
        6: n = 5'd15;
        7: n = 5'd3;
        default: n = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(1, 16));
      endcase
      phase_no++;
      settle();
      write_size(n);
      load_table($urandom_range(0, 5));
      repeat (PHASE_WORDS) begin
        // occasional stray load scrambles the order mid-stream
        if ($urandom_range(0, 19) == 0)
          send_word(bst_pkg::FUNC_LOAD, 4'($urandom_range(0, 15)), $urandom);
        else
          send_word(bst_pkg::FUNC_SEARCH, 4'($urandom_range(0, 15)), pick_target());
      end
    end
  endtask

  // Response side holds off long enough that the request side backs up.
  task automatic test_backpressure();
    settle();
    write_size(5'd16);
    send_gaps   = 1'b0;
    rsp_gaps    = 1'b0;
    hold_cycles = 60;
    repeat (40)
      send_word(bst_pkg::FUNC_SEARCH, 4'($urandom_range(0, 15)), pick_target());
  endtask

  // Response ready: long hold first, then short random bursts.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Response checker: every accepted word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      got.found       = rsp.found;
      got.position    = rsp.position;
      got.probe_count = rsp.probe_count;
      if (lookups_due.size() == 0) begin
        $error("response word with no search pending");
        error_count++;
      end else begin
        want = lookups_due.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, got.found);
          error_count++;
        end
        if (got.position !== want.position) begin
          $error("position: expected %0d, got %0d",
                 $signed(want.position), $signed(got.position));
          error_count++;
        end
        if (got.probe_count !== want.probe_count) begin
          $error("probe_count: expected %0d, got %0d",
                 want.probe_count, got.probe_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("binary_search_table_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    req.valid       <= 1'b0;
    req.func        <= bst_pkg::FUNC_LOAD;
    req.entry_index <= '0;
    req.value       <= '0;
    size_copy        = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_sorted_extremes();
    test_size_limits();
    test_random_tables(18, 1'b1);
    test_backpressure();
    test_random_tables(5, 1'b0);
    settle();

    if (error_count == 0) begin
      $display("binary_search_table_core_test: done, clean");
    end else begin
      $display("binary_search_table_core_test: done, errors");
    end
    $finish;
  end

endmodule
